// ----- rtl/sfas_pkg.sv -----
// ----------------------------------------------------------------------------
// sfas_pkg: shared types and constants of the feature accumulator stack
// Request and result layouts, request kinds, error codes, controller states.
// ----------------------------------------------------------------------------
package sfas_pkg;

	localparam int LANES_DEF    = 256;
	localparam int FEATURES_DEF = 768;
	localparam int STACK_DEF    = 64;
	localparam int NTERMS       = 5;   // weight rows touched per lane, at most
	localparam int DEPTH_OUT_W  = 7;

	typedef enum logic [2:0] {
		REQ_WR_WEIGHT = 3'd0,
		REQ_WR_BIAS   = 3'd1,
		REQ_START     = 3'd2,
		REQ_ROOT_FEAT = 3'd3,
		REQ_PUSH      = 3'd4,
		REQ_POP       = 3'd5,
		REQ_READ      = 3'd6,
		REQ_NOP       = 3'd7
	} req_kind_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_ROOT  = 2'd2,
		ERR_INDEX = 2'd3
	} err_code_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic               perspective;
		logic [9:0]         feature_a;
		logic [9:0]         feature_b;
		logic [7:0]         lane;
		logic signed [15:0] value;
		logic               has_capture;
		logic [9:0]         captured_feature;
		logic [1:0]         pair_count;
		logic [9:0]         feature_c;
		logic [9:0]         feature_d;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0]     read_value;
		logic [DEPTH_OUT_W-1:0] depth_now;
		err_code_t              error_code;
	} out_item_t;

endpackage

// ----- rtl/sfas_in_if.sv -----
// ----------------------------------------------------------------------------
// sfas_in_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface sfas_in_if;
	import sfas_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sfas_out_if.sv -----
// ----------------------------------------------------------------------------
// sfas_out_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sfas_out_if;
	import sfas_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sparse_feature_accumulator_stack_core.sv -----
// ----------------------------------------------------------------------------
// sparse_feature_accumulator_stack_core: incremental feature accumulator stack
// Weight tables, bias row and a stack of two-sided int16 accumulators, kept in
// two single-port synchronous memories and updated one lane at a time.
// ----------------------------------------------------------------------------
//  channel | dir | payload    | transaction
//  req     | in  | in_item_t  | req.valid & req.ready at clk rise
//  rsp     | out | out_item_t | rsp.valid & rsp.ready at clk rise
//
// Weight/bias writes, pop, no-op and every rejected request: result registered
// in the cycle after the transaction. Read: an accumulator-memory read, then
// the result is registered. Start root, root feature and push walk all lanes,
// each lane five weight-memory reads through the single read port plus the
// write-back. Reset clears control and depth only; memory contents are
// undefined until written. One request is in work at a time; req.ready is low
// while a lane walk runs or while a result waits and rsp.ready is low.
module sparse_feature_accumulator_stack_core #(
	parameter int LANES       = sfas_pkg::LANES_DEF,
	parameter int FEATURES    = sfas_pkg::FEATURES_DEF,
	parameter int STACK_DEPTH = sfas_pkg::STACK_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sfas_in_if.sink    req,
	sfas_out_if.source rsp
);
	import sfas_pkg::*;

	localparam int LW    = $clog2(LANES);
	localparam int WROWS = FEATURES + 1;            // last row holds the bias
	localparam int RW    = $clog2(WROWS);
	localparam int WA    = $clog2(WROWS * LANES);
	localparam int SW    = $clog2(STACK_DEPTH);
	localparam int AA    = $clog2(STACK_DEPTH * LANES);
	localparam int DW    = $clog2(STACK_DEPTH + 1);

	typedef struct packed {
		logic [RW-1:0] row;
		logic [1:0]    mask;   // bit 0 side 0 half, bit 1 side 1 half
		logic          sub;
		logic          en;
	} term_t;

	// memories: word = {side1, side0}
	logic [31:0] wmem [WROWS*LANES];
	logic [31:0] amem [STACK_DEPTH*LANES];

	state_t    state_q, state_d;
	req_kind_t op_q;
	logic      persp_q;
	logic [DW-1:0] depth_q, depth_d;
	logic [LW-1:0] lane_q;
	logic [2:0]    t_q;
	logic [SW-1:0] rd_slot_q, wr_slot_q;
	term_t         terms_q [NTERMS];
	term_t         terms_d [NTERMS];
	term_t         term_s1;
	logic [31:0]   wrd_s1, ard_s1, acc_q, acc_nxt;
	logic          out_v_q;
	out_item_t     out_d_q;

	// accept-side decode
	in_item_t  it;
	logic      take, imm, go_run, w_wr, b_wr;
	err_code_t err;
	logic      fa_ok, fb_ok, fc_ok, fd_ok, fcap_ok, lane_ok;
	logic [1:0] pairs;
	logic [SW-1:0] rd_slot_d, wr_slot_d;
	logic [LW-1:0] lane_start;

	// run-side control
	logic       issue, last_lane, fin, a_wr;
	logic [WA-1:0] w_raddr, w_waddr;
	logic [AA-1:0] a_raddr, a_waddr;
	out_item_t  fin_res, imm_res;

	assign it      = req.data;
	assign req.ready = (state_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign take    = req.valid && req.ready;

	assign fa_ok   = int'(it.feature_a) < FEATURES;
	assign fb_ok   = int'(it.feature_b) < FEATURES;
	assign fc_ok   = int'(it.feature_c) < FEATURES;
	assign fd_ok   = int'(it.feature_d) < FEATURES;
	assign fcap_ok = int'(it.captured_feature) < FEATURES;
	assign lane_ok = int'(it.lane) < LANES;
	assign pairs   = (it.pair_count == 2'd3) ? 2'd2 : it.pair_count;

	// request decode, error checks and term list
	always_comb begin
		err        = ERR_OK;
		imm        = 1'b1;
		w_wr       = 1'b0;
		b_wr       = 1'b0;
		depth_d    = depth_q;
		rd_slot_d  = SW'(depth_q - DW'(1));
		wr_slot_d  = SW'(depth_q - DW'(1));
		lane_start = '0;
		for (int k = 0; k < NTERMS; k++) terms_d[k] = '0;
		case (it.req_type)
			REQ_WR_WEIGHT: begin
				if (!fa_ok || !lane_ok) err = ERR_INDEX;
				else w_wr = 1'b1;
			end
			REQ_WR_BIAS: begin
				if (!lane_ok) err = ERR_INDEX;
				else b_wr = 1'b1;
			end
			REQ_START: begin
				imm       = 1'b0;
				depth_d   = DW'(1);
				wr_slot_d = '0;
				terms_d[0] = '{row: RW'(FEATURES), mask: 2'b11, sub: 1'b0, en: 1'b1};
			end
			REQ_ROOT_FEAT: begin
				if (depth_q == '0) err = ERR_ROOT;
				else if (!fa_ok || !fb_ok) err = ERR_INDEX;
				else begin
					imm = 1'b0;
					terms_d[0] = '{row: RW'(it.feature_a), mask: 2'b01, sub: 1'b0, en: 1'b1};
					terms_d[1] = '{row: RW'(it.feature_b), mask: 2'b10, sub: 1'b0, en: 1'b1};
				end
			end
			REQ_PUSH: begin
				if (depth_q == '0) err = ERR_ROOT;
				else if (int'(depth_q) >= STACK_DEPTH) err = ERR_FULL;
				else if ((it.has_capture && !fcap_ok) ||
				         (pairs >= 2'd1 && (!fa_ok || !fb_ok)) ||
				         (pairs >= 2'd2 && (!fc_ok || !fd_ok))) err = ERR_INDEX;
				else begin
					imm       = 1'b0;
					depth_d   = depth_q + DW'(1);
					wr_slot_d = SW'(depth_q);
					terms_d[0] = '{row: RW'(it.captured_feature), mask: 2'b11,
					               sub: 1'b1, en: it.has_capture};
					terms_d[1] = '{row: RW'(it.feature_a), mask: 2'b11, sub: 1'b0,
					               en: pairs >= 2'd1};
					terms_d[2] = '{row: RW'(it.feature_b), mask: 2'b11, sub: 1'b1,
					               en: pairs >= 2'd1};
					terms_d[3] = '{row: RW'(it.feature_c), mask: 2'b11, sub: 1'b0,
					               en: pairs >= 2'd2};
					terms_d[4] = '{row: RW'(it.feature_d), mask: 2'b11, sub: 1'b1,
					               en: pairs >= 2'd2};
				end
			end
			REQ_POP: begin
				if (depth_q <= DW'(1)) err = ERR_ROOT;
				else depth_d = depth_q - DW'(1);
			end
			REQ_READ: begin
				if (depth_q == '0) err = ERR_ROOT;
				else if (!lane_ok) err = ERR_INDEX;
				else begin
					imm        = 1'b0;
					lane_start = LW'(it.lane);
				end
			end
			default: ;
		endcase
		go_run = take && !imm;
		imm_res.read_value = '0;
		imm_res.depth_now  = DEPTH_OUT_W'(depth_d);
		imm_res.error_code = err;
	end

	// lane walk control
	assign issue     = (state_q == ST_RUN) && (t_q < 3'd5);
	assign last_lane = lane_q == LW'(LANES - 1);
	assign fin = (state_q == ST_RUN) &&
	             ((op_q == REQ_READ && t_q == 3'd1) ||
	              (op_q != REQ_READ && t_q == 3'd5 && last_lane));
	assign a_wr = (state_q == ST_RUN) && (op_q != REQ_READ) && (t_q == 3'd5);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (go_run) state_d = ST_RUN;
			ST_RUN:  if (fin) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// lane arithmetic: base plus one signed weight term per half
	always_comb begin
		logic [15:0] w, c, b;
		for (int h = 0; h < 2; h++) begin
			w = wrd_s1[h*16 +: 16];
			c = '0;
			if (term_s1.en && term_s1.mask[h]) c = term_s1.sub ? 16'(-w) : w;
			if (t_q == 3'd1) b = (op_q == REQ_START) ? 16'd0 : ard_s1[h*16 +: 16];
			else b = acc_q[h*16 +: 16];
			acc_nxt[h*16 +: 16] = b + c;
		end
		fin_res.read_value = (op_q == REQ_READ) ?
		                     (persp_q ? ard_s1[31:16] : ard_s1[15:0]) : 16'sd0;
		fin_res.depth_now  = DEPTH_OUT_W'(depth_q);
		fin_res.error_code = ERR_OK;
	end

	// addresses
	always_comb begin
		w_raddr = WA'(terms_q[(t_q < 3'd5) ? t_q : 3'd0].row) * WA'(LANES) + WA'(lane_q);
		w_waddr = (b_wr ? WA'(FEATURES) : WA'(it.feature_a)) * WA'(LANES) + WA'(it.lane);
		a_raddr = AA'(rd_slot_q) * AA'(LANES) + AA'(lane_q);
		a_waddr = AA'(wr_slot_q) * AA'(LANES) + AA'(lane_q);
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (take && w_wr && !it.perspective) wmem[w_waddr][15:0] <= it.value;
		if (take && w_wr && it.perspective)  wmem[w_waddr][31:16] <= it.value;
		if (take && b_wr) wmem[w_waddr] <= {it.value, it.value};
		if (issue) wrd_s1 <= wmem[w_raddr];
	end

	// accumulator memory
	always_ff @(posedge clk) begin
		if (a_wr) amem[a_waddr] <= acc_nxt;
		if (issue && t_q == 3'd0) ard_s1 <= amem[a_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			op_q      <= it.req_type;
			persp_q   <= it.perspective;
			rd_slot_q <= rd_slot_d;
			wr_slot_q <= wr_slot_d;
			for (int k = 0; k < NTERMS; k++) terms_q[k] <= terms_d[k];
		end
		if (issue) term_s1 <= terms_q[(t_q < 3'd5) ? t_q : 3'd0];
		if (state_q == ST_RUN && t_q != 3'd0) acc_q <= acc_nxt;
		if (take && imm) out_d_q <= imm_res;
		else if (fin) out_d_q <= fin_res;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			lane_q  <= '0;
			t_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				depth_q <= depth_d;
				lane_q  <= lane_start;
				t_q     <= '0;
			end else if (state_q == ST_RUN) begin
				if (t_q == 3'd5) begin
					t_q    <= '0;
					lane_q <= lane_q + LW'(1);
				end else begin
					t_q <= t_q + 3'd1;
				end
			end
			if ((take && imm) || fin) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_d_q;

`ifndef SYNTH
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= STACK_DEPTH)
		else $error("stack depth above limit");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !req.ready)
		else $error("request taken during lane walk");
	a_out_free_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !out_v_q)
		else $error("result pending during lane walk");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !a_wr)
		else $error("accumulator write while idle");
`endif

endmodule

// ----- dv/sfas_checker.sv -----
// ----------------------------------------------------------------------------
// sfas_checker: response scoreboard for the feature accumulator stack
// Watches both channels, keeps its own copy of the weight tables, bias row and
// accumulator stack, predicts every response and compares it in order.
// ----------------------------------------------------------------------------
module sfas_checker
	import sfas_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sfas_in_if   req,
	sfas_out_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NL = LANES_DEF;
	localparam int NF = FEATURES_DEF;
	localparam int ND = STACK_DEF;

	logic [15:0] wt_tab [2][NF*NL];
	logic [15:0] bias_words [NL];
	logic [15:0] acc_stack [ND][2][NL];
	int          stack_level;
	out_item_t   expected_rsp [$];

	// shadow update for one accepted request, returns the response it causes
	function automatic out_item_t predict_response(in_item_t r);
		out_item_t o;
		err_code_t err;
		logic [15:0] rd;
		int pc;
		err = ERR_OK;
		rd  = '0;
		pc  = (r.pair_count > 2) ? 2 : int'(r.pair_count);
		case (r.req_type)
			REQ_WR_WEIGHT: begin
				if (r.feature_a >= NF) err = ERR_INDEX;
				else wt_tab[r.perspective][r.feature_a*NL + r.lane] = r.value;
			end
			REQ_WR_BIAS: begin
				bias_words[r.lane] = r.value;
			end
			REQ_START: begin
				for (int s = 0; s < 2; s++)
					for (int i = 0; i < NL; i++) acc_stack[0][s][i] = bias_words[i];
				stack_level = 1;
			end
			REQ_ROOT_FEAT: begin
				if (stack_level == 0) err = ERR_ROOT;
				else if (r.feature_a >= NF || r.feature_b >= NF) err = ERR_INDEX;
				else begin
					for (int i = 0; i < NL; i++) begin
						acc_stack[stack_level-1][0][i] += wt_tab[0][r.feature_a*NL + i];
						acc_stack[stack_level-1][1][i] += wt_tab[1][r.feature_b*NL + i];
					end
				end
			end
			REQ_PUSH: begin
				if (stack_level == 0) err = ERR_ROOT;
				else if (stack_level >= ND) err = ERR_FULL;
				else if ((r.has_capture && r.captured_feature >= NF) ||
					(pc >= 1 && (r.feature_a >= NF || r.feature_b >= NF)) ||
					(pc >= 2 && (r.feature_c >= NF || r.feature_d >= NF)))
					err = ERR_INDEX;
				else begin
					for (int s = 0; s < 2; s++) begin
						for (int i = 0; i < NL; i++) begin
							logic [15:0] v;
							v = acc_stack[stack_level-1][s][i];
							if (r.has_capture) v -= wt_tab[s][r.captured_feature*NL + i];
							if (pc >= 1) begin
								v += wt_tab[s][r.feature_a*NL + i];
								v -= wt_tab[s][r.feature_b*NL + i];
							end
							if (pc >= 2) begin
								v += wt_tab[s][r.feature_c*NL + i];
								v -= wt_tab[s][r.feature_d*NL + i];
							end
							acc_stack[stack_level][s][i] = v;
						end
					end
					stack_level++;
				end
			end
			REQ_POP: begin
				if (stack_level <= 1) err = ERR_ROOT;
				else stack_level--;
			end
			REQ_READ: begin
				if (stack_level == 0) err = ERR_ROOT;
				else rd = acc_stack[stack_level-1][r.perspective][r.lane];
			end
			default: ;
		endcase
		o.read_value = rd;
		o.depth_now  = stack_level[DEPTH_OUT_W-1:0];
		o.error_code = err;
		return o;
	endfunction

	assign pending = expected_rsp.size();

	// response compare first, then new request prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_level = 0;
			fail_count  = 0;
			checked     = 0;
			expected_rsp.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_item_t exp_o;
				if (expected_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: response with nothing pending: %p", $realtime, rsp.data);
				end else begin
					exp_o = expected_rsp.pop_front();
					checked++;
					if (rsp.data.read_value !== exp_o.read_value ||
						rsp.data.depth_now !== exp_o.depth_now ||
						rsp.data.error_code !== exp_o.error_code) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp rd=%0d depth=%0d err=%s got rd=%0d depth=%0d err=%0d",
								$realtime, exp_o.read_value, exp_o.depth_now,
								exp_o.error_code.name(), rsp.data.read_value,
								rsp.data.depth_now, rsp.data.error_code);
					end
				end
			end
			if (req.valid && req.ready)
				expected_rsp.push_back(predict_response(req.data));
		end
	end
endmodule

// ----- dv/sparse_feature_accumulator_stack_core_tb.sv -----
// ----------------------------------------------------------------------------
// sparse_feature_accumulator_stack_core_tb: stimulus and verdict
// Loads the bias and one weight row on both sides, runs directed corner
// requests (empty stack, full stack, bad indices), then random request mixes
// with random stalls on both channels; the checker module scores every response.
// ----------------------------------------------------------------------------
module sparse_feature_accumulator_stack_core_tb;
	import sfas_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic quiet;
	int   fail_count, pending, checked;
	int   n_sent, n_push, n_read;

	// these rows are loaded in full and are the only ones that requests read back
	int   loaded_rows [1] = '{767};

	sfas_in_if  req ();
	sfas_out_if rsp ();

	sparse_feature_accumulator_stack_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sfas_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #5 clk = ~clk;

	// response side back-pressure
	always @(negedge clk) begin
		rsp.ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 9);
	end

	function automatic logic [9:0] pick_row();
		return 10'(loaded_rows[$urandom_range(0, $size(loaded_rows) - 1)]);
	endfunction

	function automatic logic [9:0] bad_row();
		return 10'($urandom_range(FEATURES_DEF, 1023));
	endfunction

	// fully random-content request that reads only loaded rows
	function automatic in_item_t make_req(req_kind_t kind);
		in_item_t it;
		it.req_type         = kind;
		it.perspective      = 1'($urandom);
		it.feature_a        = pick_row();
		it.feature_b        = pick_row();
		it.lane             = 8'($urandom);
		it.value            = 16'($urandom);
		it.has_capture      = 1'($urandom);
		it.captured_feature = pick_row();
		it.pair_count       = 2'($urandom);
		it.feature_c        = pick_row();
		it.feature_d        = pick_row();
		return it;
	endfunction

	// one transaction on the request channel, with occasional idle gaps
	task automatic send_req(in_item_t it);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req.data  = it;
		req.valid = 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		n_sent++;
		if (it.req_type == REQ_PUSH) n_push++;
		if (it.req_type == REQ_READ) n_read++;
	endtask

	task automatic send_kind(req_kind_t kind);
		send_req(make_req(kind));
	endtask

	initial begin
		#100ms;
		$display("timeout, %0d responses still pending", pending);
		$display("FAIL sparse_feature_accumulator_stack_core");
		$finish;
	end

	initial begin
		in_item_t it;
		int k;
		clk       = 1'b0;
		arst_n    = 1'b0;
		quiet     = 1'b0;
		n_sent    = 0;
		n_push    = 0;
		n_read    = 0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty stack: everything that needs a root is refused
		send_kind(REQ_READ);
		send_kind(REQ_POP);
		send_kind(REQ_PUSH);
		send_kind(REQ_ROOT_FEAT);
		send_kind(REQ_NOP);
		it = make_req(REQ_WR_WEIGHT);
		it.feature_a = 10'd1023;
		send_req(it);
		it.feature_a = 10'(FEATURES_DEF);
		send_req(it);

		// load bias and the weight rows, extremes first
		for (int l = 0; l < LANES_DEF; l++) begin
			it = make_req(REQ_WR_BIAS);
			it.lane = 8'(l);
			if (l == 0) it.value = 16'sh7fff;
			if (l == 1) it.value = 16'sh8000;
			send_req(it);
		end
		foreach (loaded_rows[r])
			for (int s = 0; s < 2; s++)
				for (int l = 0; l < LANES_DEF; l++) begin
					it = make_req(REQ_WR_WEIGHT);
					it.perspective = 1'(s);
					it.feature_a   = 10'(loaded_rows[r]);
					it.lane        = 8'(l);
					if (l < 2) it.value = (r % 2) ? 16'sh8000 : 16'sh7fff;
					send_req(it);
				end

		// root, edits, bad indices
		send_kind(REQ_START);
		it = make_req(REQ_ROOT_FEAT);
		it.feature_a = 10'd767;
		it.feature_b = 10'd767;
		send_req(it);
		it.feature_b = bad_row();
		send_req(it);
		it = make_req(REQ_PUSH);
		it.has_capture = 1'b1;
		it.pair_count  = 2'd3;
		send_req(it);
		it.captured_feature = 10'd1023;
		send_req(it);
		it = make_req(REQ_PUSH);
		it.pair_count = 2'd2;
		it.feature_d  = bad_row();
		send_req(it);
		it.feature_d = pick_row();
		it.feature_a = bad_row();
		send_req(it);
		it = make_req(REQ_READ);
		it.lane = 8'd255;
		send_req(it);
		it.lane = 8'd0;
		send_req(it);

		// fill the stack to the top, overflow once, then drain to the root
		while (u_chk.stack_level < STACK_DEF) begin
			it = make_req(REQ_PUSH);
			it.pair_count = 2'($urandom_range(0, 1));
			send_req(it);
		end
		send_kind(REQ_PUSH);
		send_kind(REQ_READ);
		for (int d = 1; d < STACK_DEF; d++) send_kind(REQ_POP);
		send_kind(REQ_POP);

		// hold off until the block has answered everything
		req.valid = 1'b0;
		while (pending != 0) @(negedge clk);

		// random mix, mostly well formed, some refused
		for (int n = 0; n < 40; n++) begin
			quiet = (n >= 10 && n < 26);
			k = $urandom_range(0, 99);
			if (k < 20)      it = make_req(REQ_READ);
			else if (k < 42) it = make_req(REQ_PUSH);
			else if (k < 58) it = make_req(REQ_POP);
			else if (k < 66) it = make_req(REQ_ROOT_FEAT);
			else if (k < 69) it = make_req(REQ_START);
			else if (k < 80) it = make_req(REQ_WR_WEIGHT);
			else if (k < 84) it = make_req(REQ_WR_BIAS);
			else if (k < 88) it = make_req(REQ_NOP);
			else if (k < 91) begin
				// weight write to a random row, possibly one that is read or out of range
				it = make_req(REQ_WR_WEIGHT);
				it.feature_a = 10'($urandom_range(0, 1023));
			end else begin
				// bad index on an edit, ignored where the edit does not use that field
				it = make_req($urandom_range(0, 1) ? REQ_PUSH : REQ_ROOT_FEAT);
				it.pair_count = 2'd3;
				case ($urandom_range(0, 4))
					0: it.feature_a = bad_row();
					1: it.feature_b = bad_row();
					2: it.feature_c = bad_row();
					3: it.feature_d = bad_row();
					default: begin
						it.has_capture      = 1'b1;
						it.captured_feature = bad_row();
					end
				endcase
			end
			send_req(it);
		end
		quiet = 1'b0;
		req.valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests (%0d pushes, %0d reads) incl. full and empty stack cases;",
			n_sent, n_push, n_read);
		$display("%0d responses checked, %0d failures", checked, fail_count);
		if (fail_count == 0) begin
			$display("PASS sparse_feature_accumulator_stack_core");
		end else begin
			$display("FAIL sparse_feature_accumulator_stack_core");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/sfas_pkg.sv
rtl/sfas_in_if.sv
rtl/sfas_out_if.sv
rtl/sparse_feature_accumulator_stack_core.sv
dv/sfas_checker.sv
dv/sparse_feature_accumulator_stack_core_tb.sv
